### sv/si2d_pkg.sv
package si2d_pkg;

  localparam int CW = 16;

  typedef struct packed {
    logic signed [CW-1:0] a_start_x;
    logic signed [CW-1:0] a_start_y;
    logic signed [CW-1:0] a_end_x;
    logic signed [CW-1:0] a_end_y;
    logic signed [CW-1:0] b_start_x;
    logic signed [CW-1:0] b_start_y;
    logic signed [CW-1:0] b_end_x;
    logic signed [CW-1:0] b_end_y;
  } in_item_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
  } out_item_t;

endpackage

### sv/segment_intersection_2d_top.sv
// Segment pair intersection, fully pipelined.
// Input channel: drive in_item and raise start; the item is taken at any
// rising edge with start high and busy low. busy is held low: one item may
// enter every clock cycle.
// Result channel: out_valid is high for exactly one cycle with out_item,
// once the item has passed the registered stages in order (difference
// stage, cross products, range test, one division stage per fraction bit
// of t, product and final add). Throughput is one item per cycle, since every
// stage, including the one-bit-per-stage restoring divider for t, is pipelined.
// The receiver cannot stall, so the pipeline never holds.
// Reset (rst_n low, synchronous) clears all valid bits; data registers are
// left as they are. No result appears for an item that did not enter.
// A miss (parallel segments or t, u outside [0,1]) yields hit 0 and a
// zero point.
module segment_intersection_2d_top #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  si2d_pkg::in_item_t  in_item,
  output logic                out_valid,
  output si2d_pkg::out_item_t out_item
);
  import si2d_pkg::*;

  localparam int DW = CW + 1;         // differences
  localparam int NW = 2 * DW + 1;     // cross products
  localparam int QW = T_FRAC_BITS + 1;
  localparam int PW = DW + QW;

  assign busy = 1'b0;

  // stage 1: differences
  logic v1_r;
  logic signed [DW-1:0] rx1_r, ry1_r, sx1_r, sy1_r, dx1_r, dy1_r;
  logic signed [CW-1:0] px1_r, py1_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
    rx1_r <= DW'(in_item.a_end_x) - DW'(in_item.a_start_x);
    ry1_r <= DW'(in_item.a_end_y) - DW'(in_item.a_start_y);
    sx1_r <= DW'(in_item.b_end_x) - DW'(in_item.b_start_x);
    sy1_r <= DW'(in_item.b_end_y) - DW'(in_item.b_start_y);
    dx1_r <= DW'(in_item.b_start_x) - DW'(in_item.a_start_x);
    dy1_r <= DW'(in_item.b_start_y) - DW'(in_item.a_start_y);
    px1_r <= in_item.a_start_x;
    py1_r <= in_item.a_start_y;
  end

  // stage 2: products of the cross terms
  logic v2_r;
  logic signed [2*DW-1:0] m_r [6];
  logic signed [DW-1:0] rx2_r, ry2_r;
  logic signed [CW-1:0] px2_r, py2_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    m_r[0] <= rx1_r * sy1_r;
    m_r[1] <= ry1_r * sx1_r;
    m_r[2] <= dx1_r * sy1_r;
    m_r[3] <= dy1_r * sx1_r;
    m_r[4] <= dx1_r * ry1_r;
    m_r[5] <= dy1_r * rx1_r;
    rx2_r <= rx1_r; ry2_r <= ry1_r; px2_r <= px1_r; py2_r <= py1_r;
  end

  // stage 3: cross products, range test, magnitudes
  logic signed [NW-1:0] den, tn, un;
  logic [NW-1:0] dmag, tmag, umag;
  logic ok;
  always_comb begin
    den  = NW'(m_r[0]) - NW'(m_r[1]);
    tn   = NW'(m_r[2]) - NW'(m_r[3]);
    un   = NW'(m_r[4]) - NW'(m_r[5]);
    dmag = den[NW-1] ? NW'(-den) : NW'(den);
    tmag = tn[NW-1] ? NW'(-tn) : NW'(tn);
    umag = un[NW-1] ? NW'(-un) : NW'(un);
    ok   = (den != '0)
        && !(tn != '0 && (tn[NW-1] != den[NW-1])) && (tmag <= dmag)
        && !(un != '0 && (un[NW-1] != den[NW-1])) && (umag <= dmag);
  end

  logic v3_r, ok3_r;
  logic [NW-1:0] rem3_r, dm3_r;
  logic [QW-1:0] q3_r;
  logic signed [DW-1:0] rx3_r, ry3_r;
  logic signed [CW-1:0] px3_r, py3_r;
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    ok3_r <= ok;
    // integer part of t is 1 only when |tn| equals |den|
    if (ok && tmag == dmag) begin
      rem3_r <= '0;
      q3_r   <= QW'(1);
    end else begin
      rem3_r <= tmag;
      q3_r   <= '0;
    end
    dm3_r <= dmag;
    rx3_r <= rx2_r; ry3_r <= ry2_r; px3_r <= px2_r; py3_r <= py2_r;
  end

  // division stages: one fraction bit of t per stage
  logic            dv_r  [T_FRAC_BITS+1];
  logic            dok_r [T_FRAC_BITS+1];
  logic [NW-1:0]   drem_r[T_FRAC_BITS+1];
  logic [NW-1:0]   ddm_r [T_FRAC_BITS+1];
  logic [QW-1:0]   dq_r  [T_FRAC_BITS+1];
  logic signed [DW-1:0] drx_r[T_FRAC_BITS+1], dry_r[T_FRAC_BITS+1];
  logic signed [CW-1:0] dpx_r[T_FRAC_BITS+1], dpy_r[T_FRAC_BITS+1];

  always_comb begin
    dv_r[0] = v3_r; dok_r[0] = ok3_r; drem_r[0] = rem3_r; ddm_r[0] = dm3_r;
    dq_r[0] = q3_r; drx_r[0] = rx3_r; dry_r[0] = ry3_r;
    dpx_r[0] = px3_r; dpy_r[0] = py3_r;
  end

  for (genvar g = 0; g < T_FRAC_BITS; g++) begin : g_div
    logic [NW-1:0] rem_nxt;
    logic [QW-1:0] q_nxt;
    si2d_div_step #(.NW(NW), .QW(QW)) u_step (
      .rem_i(drem_r[g]), .dm_i(ddm_r[g]), .q_i(dq_r[g]),
      .rem_o(rem_nxt), .q_o(q_nxt)
    );
    always_ff @(posedge clk) begin
      if (!rst_n) dv_r[g+1] <= 1'b0;
      else        dv_r[g+1] <= dv_r[g];
      dok_r[g+1]  <= dok_r[g];
      drem_r[g+1] <= rem_nxt;
      ddm_r[g+1]  <= ddm_r[g];
      dq_r[g+1]   <= q_nxt;
      drx_r[g+1]  <= drx_r[g]; dry_r[g+1] <= dry_r[g];
      dpx_r[g+1]  <= dpx_r[g]; dpy_r[g+1] <= dpy_r[g];
    end
  end

  // product stage: |r| * t
  localparam int L = T_FRAC_BITS;
  logic [DW-1:0] amx, amy;
  assign amx = drx_r[L][DW-1] ? DW'(-drx_r[L]) : DW'(drx_r[L]);
  assign amy = dry_r[L][DW-1] ? DW'(-dry_r[L]) : DW'(dry_r[L]);

  logic vp_r, okp_r, nx_r, ny_r;
  logic [PW-1:0] prx_r, pry_r;
  logic signed [CW-1:0] ppx_r, ppy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vp_r <= 1'b0;
    else        vp_r <= dv_r[L];
    okp_r <= dok_r[L];
    prx_r <= PW'(amx) * PW'(dq_r[L]);
    pry_r <= PW'(amy) * PW'(dq_r[L]);
    nx_r  <= drx_r[L][DW-1];
    ny_r  <= dry_r[L][DW-1];
    ppx_r <= dpx_r[L]; ppy_r <= dpy_r[L];
  end

  // final stage: round towards minus infinity and add to p
  localparam logic [PW-1:0] RADD = PW'((64'd1 << T_FRAC_BITS) - 64'd1);
  logic [PW-1:0] ox, oy;
  logic [CW-1:0] fx, fy;
  always_comb begin
    ox = nx_r ? (prx_r + RADD) >> T_FRAC_BITS : prx_r >> T_FRAC_BITS;
    oy = ny_r ? (pry_r + RADD) >> T_FRAC_BITS : pry_r >> T_FRAC_BITS;
    fx = nx_r ? CW'(ppx_r) - ox[CW-1:0] : CW'(ppx_r) + ox[CW-1:0];
    fy = ny_r ? CW'(ppy_r) - oy[CW-1:0] : CW'(ppy_r) + oy[CW-1:0];
  end

  logic      vo_r;
  out_item_t o_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else        vo_r <= vp_r;
    o_r.hit     <= okp_r;
    o_r.point_x <= okp_r ? fx : '0;
    o_r.point_y <= okp_r ? fy : '0;
  end

  assign out_valid = vo_r;
  assign out_item  = o_r;
endmodule

### sv/si2d_div_step.sv
// One restoring division step: shift in a zero, subtract the divisor if it fits.
module si2d_div_step #(
  parameter int NW = 36,
  parameter int QW = 17
) (
  input  logic [NW-1:0] rem_i,
  input  logic [NW-1:0] dm_i,
  input  logic [QW-1:0] q_i,
  output logic [NW-1:0] rem_o,
  output logic [QW-1:0] q_o
);
  logic [NW:0] sh;
  assign sh    = {rem_i, 1'b0};
  always_comb begin
    if (sh >= {1'b0, dm_i}) begin
      rem_o = NW'(sh - {1'b0, dm_i});
      q_o   = {q_i[QW-2:0], 1'b1};
    end else begin
      rem_o = NW'(sh);
      q_o   = {q_i[QW-2:0], 1'b0};
    end
  end
endmodule

### verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import si2d_pkg::*;

  localparam int TFB       = 16;
  localparam int LATENCY   = 5 + TFB;
  localparam int MAX_CYCLES = 200000;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  out_item_t expected_hits[$];
  int        n_errors;
  int        n_cycles;
  bit        allow_gaps;

  segment_intersection_2d_top #(.T_FRAC_BITS(TFB)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  // Free-running clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog on total run length
  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > MAX_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Cross product at full 64-bit width
  function automatic longint cross_2d(longint ax, longint ay, longint bx, longint by);
    return ax * by - ay * bx;
  endfunction

  // True when num/den lies in [0,1]
  function automatic bit in_unit_span(longint num, longint den);
    longint nm;
    longint dm;
    nm = (num < 0) ? -num : num;
    dm = (den < 0) ? -den : den;
    if (num != 0 && ((num < 0) != (den < 0))) return 1'b0;
    return nm <= dm;
  endfunction

  // Predict hit flag and intersection point for one segment pair
  function automatic out_item_t predict_crossing(in_item_t it);
    out_item_t res;
    longint px, py, rx, ry, sx, sy, dx, dy, den, tn, un;
    longint unsigned dm, tq, prod, off;
    longint rv[2];
    longint pv[2];
    logic [CW-1:0] pt[2];
    px  = it.a_start_x;
    py  = it.a_start_y;
    rx  = longint'(it.a_end_x) - px;
    ry  = longint'(it.a_end_y) - py;
    sx  = longint'(it.b_end_x) - longint'(it.b_start_x);
    sy  = longint'(it.b_end_y) - longint'(it.b_start_y);
    dx  = longint'(it.b_start_x) - px;
    dy  = longint'(it.b_start_y) - py;
    den = cross_2d(rx, ry, sx, sy);
    tn  = cross_2d(dx, dy, sx, sy);
    un  = cross_2d(dx, dy, rx, ry);
    res = '0;
    if (den == 0 || !in_unit_span(tn, den) || !in_unit_span(un, den)) return res;
    // t = |tn|/|den| truncated to TFB fraction bits; |tn| <= |den| < 2^35
    dm = (den < 0) ? -den : den;
    tq = (((tn < 0) ? -tn : tn) << TFB) / dm;
    rv[0] = rx; rv[1] = ry;
    pv[0] = px; pv[1] = py;
    for (int i = 0; i < 2; i++) begin
      prod = ((rv[i] < 0) ? -rv[i] : rv[i]) * tq;
      if (rv[i] >= 0) begin
        off   = prod >> TFB;
        pt[i] = CW'(pv[i] + longint'(off));
      end else begin
        off   = (prod + ((64'd1 << TFB) - 1)) >> TFB;
        pt[i] = CW'(pv[i] - longint'(off));
      end
    end
    res.hit     = 1'b1;
    res.point_x = pt[0];
    res.point_y = pt[1];
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    n_errors++;
  endtask

  // Check each result against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = expected_hits.pop_front();
        if (out_item.hit !== want.hit) report_mismatch("hit", out_item.hit, want.hit);
        if (out_item.point_x !== want.point_x)
          report_mismatch("point_x", out_item.point_x, want.point_x);
        if (out_item.point_y !== want.point_y)
          report_mismatch("point_y", out_item.point_y, want.point_y);
      end
    end
  end

  // Send one item, with an occasional gap burst beforehand
  task automatic send_pair(in_item_t it);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    expected_hits.push_back(predict_crossing(it));
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_hits.size() != 0) @(posedge clk);
  endtask

  function automatic in_item_t make_pair(int x0, int y0, int x1, int y1,
                                         int x2, int y2, int x3, int y3);
    in_item_t it;
    it = {CW'(x0), CW'(y0), CW'(x1), CW'(y1), CW'(x2), CW'(y2), CW'(x3), CW'(y3)};
    return it;
  endfunction

  // Extremes, parallel and collinear pairs, end-point touches, near misses
  task automatic test_directed();
    send_pair(make_pair(-256, 0, 256, 0, 0, -256, 0, 256));
    send_pair(make_pair(0, 0, 256, 0, 0, 256, 256, 256));
    send_pair(make_pair(0, 0, 512, 0, 256, 0, 768, 0));
    send_pair(make_pair(0, 0, 256, 256, 256, 256, 512, 0));
    send_pair(make_pair(0, 0, 256, 0, 0, 0, 0, 256));
    send_pair(make_pair(0, 0, 256, 0, 257, -256, 257, 256));
    send_pair(make_pair(0, 0, 256, 0, 128, 1, 128, 256));
    send_pair(make_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
    send_pair(make_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767));
    send_pair(make_pair(-32768, 0, 32767, 0, 0, -32768, 1, 32767));
    send_pair(make_pair(5, 5, 5, 5, 5, 5, 5, 5));
    send_pair(make_pair(0, 0, 0, 0, -10, 0, 10, 0));
    send_pair(make_pair(0, 0, -300, -7, -100, 50, -101, -60));
    send_pair(make_pair(0, 0, 3, 0, 1, -1, 2, 1));
    send_pair(make_pair(32767, 32767, -32768, -32768, 32767, 32767, 32767, -32768));
    send_pair(make_pair(-1, -1, -1, -1, -1, -1, -1, -1));
    drain_results();
  endtask

  // Random pairs: mostly built to cross, rest uniform noise
  task automatic test_random(int count);
    in_item_t it;
    int cx, cy, span;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 2) == 0) begin
        it = in_item_t'({$urandom, $urandom, $urandom, $urandom});
      end else begin
        span = ($urandom_range(0, 3) == 0) ? 32767 : $urandom_range(1, 2000);
        cx = $urandom_range(0, 65535) - 32768;
        cy = $urandom_range(0, 65535) - 32768;
        it = make_pair(cx - $urandom_range(0, span), cy - $urandom_range(0, span),
                       cx + $urandom_range(0, span), cy + $urandom_range(0, span),
                       cx - $urandom_range(0, span), cy + $urandom_range(0, span),
                       cx + $urandom_range(0, span), cy - $urandom_range(0, span));
      end
      send_pair(it);
    end
  endtask

  initial begin
    n_errors   = 0;
    allow_gaps = 1'b1;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(800);
    // hold off until the pipeline has emptied, then resume
    drain_results();
    test_random(600);
    allow_gaps = 1'b0;
    test_random(300);
    drain_results();
    repeat (LATENCY + 5) @(posedge clk);

    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/si2d_pkg.sv
sv/si2d_div_step.sv
sv/segment_intersection_2d_top.sv
verif/tb.sv
